### rtl/aopd_pkg.sv
`default_nettype none

package aopd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MODE_W   = 2;
   localparam int PULSE_W  = 16;
   localparam int POWER_W  = 31;
   localparam int SUM_W    = 43;
   localparam int TALLY_W  = 13;
   localparam int PROD_W   = 47;
   localparam int CNT_W    = 6;

   localparam int MAX_FRAMES = 4096;
   localparam int MUL_STEPS  = 16;
   localparam int DIV_STEPS  = SUM_W;

   localparam logic [POWER_W-1:0] POWER_FULL = POWER_W'(1) << 30;
   localparam int CHANGE_ROUND   = 5;
   localparam int CHANGE_DIVISOR = 10;
   localparam int ONSET_SHIFT    = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic                  STEREO_RESET = 1'b1;
   localparam logic [CSR_DATA_W-1:0] GAIN_RESET   = 16'd512;
   localparam logic [CSR_DATA_W-1:0] PEAK_RESET   = 16'd4096;
   localparam logic [CSR_DATA_W-1:0] FLOOR_RESET  = 16'd0;
   localparam logic [CSR_DATA_W-1:0] DECAY_RESET  = 16'd58982;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEREO_INPUT   = 3'd0,
      CSR_THRESHOLD_GAIN = 3'd1,
      CSR_PULSE_PEAK     = 3'd2,
      CSR_PULSE_FLOOR    = 3'd3,
      CSR_DECAY_FACTOR   = 3'd4
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_END    = 2'd1,
      MODE_SILENT = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_SQUARE   = 12'b0000_0000_0010,
      S_ACCUM    = 12'b0000_0000_0100,
      S_ENDBUF   = 12'b0000_0000_1000,
      S_DIVMEAN  = 12'b0000_0001_0000,
      S_MEAN     = 12'b0000_0010_0000,
      S_DIFF     = 12'b0000_0100_0000,
      S_DELTA    = 12'b0000_1000_0000,
      S_DIVSTEP  = 12'b0001_0000_0000,
      S_TRACK    = 12'b0010_0000_0000,
      S_MULGAIN  = 12'b0100_0000_0000,
      S_ONSET    = 12'b1000_0000_0000
   } state_type;

endpackage

`default_nettype wire

### rtl/aopd_req_if.sv
`default_nettype none

interface aopd_req_if;
   logic                                valid;
   logic                                ready;
   logic [aopd_pkg::MODE_W-1:0]         mode;
   logic signed [aopd_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [aopd_pkg::SAMPLE_W-1:0] right_sample;

   modport source (output valid, output mode, output left_sample, output right_sample,
                   input ready);
   modport sink (input valid, input mode, input left_sample, input right_sample,
                 output ready);
endinterface

`default_nettype wire

### rtl/aopd_rsp_if.sv
`default_nettype none

interface aopd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [aopd_pkg::PULSE_W-1:0] amplitude;
   logic [aopd_pkg::POWER_W-1:0] mean_power;

   modport source (output valid, output amplitude, output mean_power, input ready);
   modport sink (input valid, input amplitude, input mean_power, output ready);
endinterface

`default_nettype wire

### rtl/audio_onset_pulse_detector_unit.sv
// Onset pulse detector for a PCM audio stream.
// Frames arrive as transactions on req_if (mode, left_sample, right_sample). A mode 0
// frame is squared and added to the buffer sum; a mode 1 frame is added and then ends
// the buffer; a mode 2 tick runs the pulse update with zero power; mode 3 is dropped.
// Mode 1 and mode 2 each give one transaction on rsp_if carrying the decayed pulse
// amplitude and the buffer mean power.
// Work per transaction: the block takes one transaction at a time. A sample frame runs
// through the bit-serial squarer. A buffer end runs the squarer, two restoring
// divisions (sum by frame count, then the tracked change step by ten) and two shift-add
// multiplications. A silent tick runs only the step division and the multiplications.
// A sample that finds the buffer full, and mode 3, are dropped.
// Results go into an output register. While a stalled rsp_if receiver holds it, the
// next finished result waits in a pending stage and no new frame is taken until it moves.
// Reset is synchronous and active high. It clears the sum, the frame count, the power history
// and the pulse, and loads the default register values. The user must write registers through
// csr_write_enable, csr_index and csr_write_data only while the block is idle (unchecked).
`default_nettype none

module audio_onset_pulse_detector_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   aopd_req_if.sink                             req_if,
   aopd_rsp_if.source                           rsp_if,
   input  wire logic                            csr_write_enable,
   input  wire logic [aopd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [aopd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import aopd_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  end_ff, end_in;
   logic                  up_ff, up_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [TALLY_W-1:0]    tally_ff, tally_in;
   logic [POWER_W-1:0]    prev_ff, prev_in;
   logic [POWER_W-1:0]    tc_ff, tc_in;
   logic [PULSE_W-1:0]    pulse_ff, pulse_in;
   logic [POWER_W-1:0]    p_ff, p_in;
   logic [POWER_W-1:0]    d_ff, d_in;
   logic [PROD_W-1:0]     mcand_ff, mcand_in;
   logic [MUL_STEPS-1:0]  mplier_ff, mplier_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [SUM_W-1:0]      dvd_ff, dvd_in;
   logic [TALLY_W-1:0]    rem_ff, rem_in;
   logic [TALLY_W-1:0]    dvsr_ff, dvsr_in;
   logic                  stereo_ff, stereo_in;
   logic [CSR_DATA_W-1:0] gain_ff, gain_in;
   logic [CSR_DATA_W-1:0] peak_ff, peak_in;
   logic [CSR_DATA_W-1:0] floor_ff, floor_in;
   logic [CSR_DATA_W-1:0] decay_ff, decay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]    rsp_amp_ff, rsp_amp_in;
   logic [POWER_W-1:0]    rsp_pow_ff, rsp_pow_in;

   logic                  out_pending_ff, out_pending_in;

   // Marks that the shared multiplier runs the decay product of an update.
   logic                  decay_run_ff, decay_run_in;

   // Downmix: in stereo the sum of two samples halved, rounded toward zero; else the left one.
   logic signed [SAMPLE_W:0]   lr_sum;
   logic signed [SAMPLE_W:0]   lr_adj;
   logic signed [SAMPLE_W-1:0] mono;
   logic [SAMPLE_W-1:0]        mono_abs;

   logic [PROD_W-1:0]     mul_sum;
   logic [TALLY_W:0]      div_trial;
   logic [TALLY_W:0]      div_diff;
   logic                  div_ge;
   logic [SUM_W:0]        sum_wide;
   logic [POWER_W-1:0]    change_mag;
   logic [POWER_W:0]      change_round;
   logic [POWER_W-1:0]    change_step;
   logic [POWER_W-1:0]    tc_next;
   logic [POWER_W-1:0]    rise;
   logic                  onset;
   logic [PULSE_W-1:0]    pulse_sel;
   logic [PULSE_W-1:0]    decayed;
   logic [PULSE_W-1:0]    capped;

   assign lr_sum   = {req_if.left_sample[SAMPLE_W-1], req_if.left_sample}
                   + {req_if.right_sample[SAMPLE_W-1], req_if.right_sample};
   assign lr_adj   = lr_sum + (SAMPLE_W + 1)'(lr_sum[SAMPLE_W]);
   assign mono     = stereo_ff ? lr_adj[SAMPLE_W:1] : req_if.left_sample;
   assign mono_abs = mono[SAMPLE_W-1] ? SAMPLE_W'(-mono) : SAMPLE_W'(mono);

   assign mul_sum  = prod_ff + (mplier_ff[0] ? mcand_ff : '0);

   assign div_trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign div_ge    = div_trial >= {1'b0, dvsr_ff};
   assign div_diff  = div_trial - {1'b0, dvsr_ff};

   assign sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(prod_ff[POWER_W-1:0]);

   assign change_mag   = (d_ff >= tc_ff) ? d_ff - tc_ff : tc_ff - d_ff;
   assign change_round = {1'b0, change_mag} + (POWER_W + 1)'(CHANGE_ROUND);
   assign change_step  = dvd_ff[POWER_W-1:0];
   assign tc_next      = up_ff ? tc_ff + change_step : tc_ff - change_step;

   assign rise      = p_ff - prev_ff;
   assign onset     = (p_ff > prev_ff)
                    && (PROD_W'({rise, ONSET_SHIFT'(0)}) > prod_ff);
   assign pulse_sel = onset ? peak_ff : pulse_ff;
   // The last partial product is still being added when the decay finishes.
   assign decayed   = mul_sum[2*PULSE_W-1:PULSE_W];
   assign capped    = (decayed > peak_ff) ? peak_ff : decayed;

   assign req_if.ready      = (state_ff == S_IDLE) && !out_pending_ff;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.amplitude  = rsp_amp_ff;
   assign rsp_if.mean_power = rsp_pow_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      end_in         = end_ff;
      up_in          = up_ff;
      sum_in         = sum_ff;
      tally_in       = tally_ff;
      prev_in        = prev_ff;
      tc_in          = tc_ff;
      pulse_in       = pulse_ff;
      p_in           = p_ff;
      d_in           = d_ff;
      mcand_in       = mcand_ff << 1;
      mplier_in      = mplier_ff >> 1;
      prod_in        = mul_sum;
      dvd_in         = {dvd_ff[SUM_W-2:0], div_ge};
      rem_in         = div_ge ? div_diff[TALLY_W-1:0] : div_trial[TALLY_W-1:0];
      dvsr_in        = dvsr_ff;
      stereo_in      = stereo_ff;
      gain_in        = gain_ff;
      peak_in        = peak_ff;
      floor_in       = floor_ff;
      decay_in       = decay_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_amp_in     = rsp_amp_ff;
      rsp_pow_in     = rsp_pow_ff;
      out_pending_in = out_pending_ff;

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_STEREO_INPUT:   stereo_in = csr_write_data[0];
            CSR_THRESHOLD_GAIN: gain_in   = csr_write_data;
            CSR_PULSE_PEAK:     peak_in   = csr_write_data;
            CSR_PULSE_FLOOR:    floor_in  = csr_write_data;
            CSR_DECAY_FACTOR:   decay_in  = csr_write_data;
            default: ;
         endcase
      end

      // A finished result moves to the output register once it is free.
      if (out_pending_ff && (!rsp_valid_ff || rsp_if.ready)) begin
         rsp_valid_in   = 1'b1;
         rsp_amp_in     = pulse_ff;
         rsp_pow_in     = prev_ff;
         out_pending_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid && !out_pending_ff) begin
               case (mode_type'(req_if.mode))
                  MODE_SAMPLE, MODE_END: begin
                     end_in = (mode_type'(req_if.mode) == MODE_END);
                     if (tally_ff < TALLY_W'(MAX_FRAMES)) begin
                        mcand_in  = PROD_W'(mono_abs);
                        mplier_in = mono_abs;
                        prod_in   = '0;
                        cnt_in    = CNT_W'(MUL_STEPS - 1);
                        state_in  = S_SQUARE;
                     end else if (mode_type'(req_if.mode) == MODE_END) begin
                        state_in = S_ENDBUF;
                     end
                  end
                  MODE_SILENT: begin
                     p_in     = '0;
                     state_in = S_DIFF;
                  end
                  default: ;
               endcase
            end
         end
         S_SQUARE: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            tally_in = tally_ff + 1'b1;
            state_in = end_ff ? S_ENDBUF : S_IDLE;
         end
         S_ENDBUF: begin
            sum_in   = '0;
            tally_in = '0;
            if (tally_ff == '0) begin
               p_in     = '0;
               state_in = S_DIFF;
            end else begin
               dvd_in   = sum_ff;
               rem_in   = '0;
               dvsr_in  = tally_ff;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               state_in = S_DIVMEAN;
            end
         end
         S_DIVMEAN: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            p_in     = (dvd_ff > SUM_W'(POWER_FULL)) ? POWER_FULL : dvd_ff[POWER_W-1:0];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            d_in     = (p_ff >= prev_ff) ? p_ff - prev_ff : prev_ff - p_ff;
            state_in = S_DELTA;
         end
         S_DELTA: begin
            up_in    = d_ff >= tc_ff;
            dvd_in   = SUM_W'(change_round);
            rem_in   = '0;
            dvsr_in  = TALLY_W'(CHANGE_DIVISOR);
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = S_DIVSTEP;
         end
         S_DIVSTEP: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_TRACK;
            end
         end
         S_TRACK: begin
            tc_in     = tc_next;
            mcand_in  = PROD_W'(tc_next);
            mplier_in = gain_ff;
            prod_in   = '0;
            cnt_in    = CNT_W'(MUL_STEPS - 1);
            state_in  = S_MULGAIN;
         end
         S_MULGAIN: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_ONSET;
            end
         end
         S_ONSET: begin
            // The decay multiply reuses the squarer; decay_run_ff marks it for the finish.
            mcand_in  = PROD_W'(pulse_sel);
            mplier_in = decay_ff;
            prod_in   = '0;
            cnt_in    = CNT_W'(MUL_STEPS - 1);
            end_in    = 1'b0;
            up_in     = 1'b1;
            state_in  = S_SQUARE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The squarer state also runs the decay multiply; decay_run_ff tells the two
      // uses apart at the end of the count.
      if (state_ff == S_SQUARE && cnt_ff == '0 && decay_run_ff) begin
         pulse_in       = (capped < floor_ff) ? floor_ff : capped;
         prev_in        = p_ff;
         out_pending_in = 1'b1;
         state_in       = S_IDLE;
      end
   end

   always_comb begin
      decay_run_in = decay_run_ff;
      if (state_ff == S_ONSET) begin
         decay_run_in = 1'b1;
      end else if (state_ff == S_SQUARE && cnt_ff == '0) begin
         decay_run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         end_ff         <= 1'b0;
         decay_run_ff   <= 1'b0;
         sum_ff         <= '0;
         tally_ff       <= '0;
         prev_ff        <= '0;
         tc_ff          <= '0;
         pulse_ff       <= '0;
         stereo_ff      <= STEREO_RESET;
         gain_ff        <= GAIN_RESET;
         peak_ff        <= PEAK_RESET;
         floor_ff       <= FLOOR_RESET;
         decay_ff       <= DECAY_RESET;
         rsp_valid_ff   <= 1'b0;
         out_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         end_ff         <= end_in;
         decay_run_ff   <= decay_run_in;
         sum_ff         <= sum_in;
         tally_ff       <= tally_in;
         prev_ff        <= prev_in;
         tc_ff          <= tc_in;
         pulse_ff       <= pulse_in;
         stereo_ff      <= stereo_in;
         gain_ff        <= gain_in;
         peak_ff        <= peak_in;
         floor_ff       <= floor_in;
         decay_ff       <= decay_in;
         rsp_valid_ff   <= rsp_valid_in;
         out_pending_ff <= out_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff      <= up_in;
      p_ff       <= p_in;
      d_ff       <= d_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      prod_ff    <= prod_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      dvsr_ff    <= dvsr_in;
      rsp_amp_ff <= rsp_amp_in;
      rsp_pow_ff <= rsp_pow_in;
   end

endmodule

`default_nettype wire

### tb/onset_pulse_checker.sv
module onset_pulse_checker (
   input  logic                             clock,
   input  logic                             reset,
   aopd_req_if                              frame_bus,
   aopd_rsp_if                              pulse_bus,
   input  logic                             csr_write_enable,
   input  logic [aopd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [aopd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               error_count,
   output int                               awaited_count
);
   import aopd_pkg::*;

   typedef struct packed {
      logic [PULSE_W-1:0] amplitude;
      logic [POWER_W-1:0] mean_power;
   } pulse_result_type;

   localparam longint SUM_CEILING = (longint'(1) << SUM_W) - 1;

   // Shadow copies of the configuration registers.
   logic   stereo_on;
   longint gain_q8;
   longint peak_level;
   longint floor_level;
   longint decay_q16;

   // Shadow copy of the detector state.
   longint square_sum;
   longint last_power;
   longint tracked_change;
   longint pulse_level;
   int     frame_tally;

   pulse_result_type awaited_pulses[$];
   int               mismatches = 0;

   task automatic report_mismatch(input string line);
      $display("%0t: %s", $time, line);
      mismatches++;
   endtask

   function automatic void tally_frame(input logic signed [SAMPLE_W-1:0] left,
                                       input logic signed [SAMPLE_W-1:0] right);
      int     mono;
      longint square;
      // Integer division of a signed sum truncates toward zero, as the downmix does.
      mono = stereo_on ? (int'(left) + int'(right)) / 2 : int'(left);
      if (frame_tally >= MAX_FRAMES)
         return;
      square = longint'(mono) * longint'(mono);
      if (square_sum > SUM_CEILING - square)
         square_sum = SUM_CEILING;
      else
         square_sum += square;
      frame_tally++;
   endfunction

   function automatic pulse_result_type advance_pulse(input longint power);
      longint           change;
      longint           scaled;
      pulse_result_type result;
      change = (power >= last_power) ? power - last_power : last_power - power;
      // A tenth of the gap, rounded half away from zero.
      if (change >= tracked_change)
         tracked_change += (change - tracked_change + CHANGE_ROUND) / CHANGE_DIVISOR;
      else
         tracked_change -= (tracked_change - change + CHANGE_ROUND) / CHANGE_DIVISOR;
      if (power > last_power &&
          ((power - last_power) << ONSET_SHIFT) > tracked_change * gain_q8)
         pulse_level = peak_level;
      scaled = (pulse_level * decay_q16) >> 16;
      if (scaled > peak_level)
         scaled = peak_level;
      // The floor is applied last, so it wins when it sits above the peak.
      if (scaled < floor_level)
         scaled = floor_level;
      pulse_level       = scaled;
      last_power        = power;
      result.amplitude  = PULSE_W'(pulse_level);
      result.mean_power = POWER_W'(power);
      return result;
   endfunction

   function automatic void predict_frame(input mode_type mode,
                                         input logic signed [SAMPLE_W-1:0] left,
                                         input logic signed [SAMPLE_W-1:0] right);
      longint power;
      power = 0;
      case (mode)
         MODE_SAMPLE: tally_frame(left, right);
         MODE_END: begin
            tally_frame(left, right);
            if (frame_tally != 0) begin
               power = square_sum / frame_tally;
               if (power > longint'(POWER_FULL))
                  power = longint'(POWER_FULL);
            end
            square_sum  = 0;
            frame_tally = 0;
            awaited_pulses.push_back(advance_pulse(power));
         end
         MODE_SILENT: awaited_pulses.push_back(advance_pulse(0));
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      pulse_result_type oldest;
      if (reset) begin
         stereo_on      = STEREO_RESET;
         gain_q8        = GAIN_RESET;
         peak_level     = PEAK_RESET;
         floor_level    = FLOOR_RESET;
         decay_q16      = DECAY_RESET;
         square_sum     = 0;
         frame_tally    = 0;
         last_power     = 0;
         tracked_change = 0;
         pulse_level    = 0;
         awaited_pulses.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_STEREO_INPUT:   stereo_on   = csr_write_data[0];
               CSR_THRESHOLD_GAIN: gain_q8     = csr_write_data;
               CSR_PULSE_PEAK:     peak_level  = csr_write_data;
               CSR_PULSE_FLOOR:    floor_level = csr_write_data;
               CSR_DECAY_FACTOR:   decay_q16   = csr_write_data;
               default: ;
            endcase
         end
         // Results are checked before the new frame is predicted; a result leaving
         // now always belongs to an earlier transaction.
         if (pulse_bus.valid && pulse_bus.ready) begin
            if (awaited_pulses.size() == 0) begin
               report_mismatch($sformatf("result with none awaited: amplitude %0d power %0d",
                                         pulse_bus.amplitude, pulse_bus.mean_power));
            end else begin
               oldest = awaited_pulses.pop_front();
               if (pulse_bus.amplitude !== oldest.amplitude)
                  report_mismatch($sformatf("amplitude: got %0d, expected %0d",
                                            pulse_bus.amplitude, oldest.amplitude));
               if (pulse_bus.mean_power !== oldest.mean_power)
                  report_mismatch($sformatf("mean_power: got %0d, expected %0d",
                                            pulse_bus.mean_power, oldest.mean_power));
            end
         end
         if (frame_bus.valid && frame_bus.ready)
            predict_frame(mode_type'(frame_bus.mode), frame_bus.left_sample,
                          frame_bus.right_sample);
      end
      error_count   <= mismatches;
      awaited_count <= awaited_pulses.size();
   end

endmodule

### tb/tb.sv
module tb;
   import aopd_pkg::*;

   localparam int SETTLE_CYCLES = 200;
   localparam int QUIET_LIMIT   = 4000;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   rsp_ready        = 1'b0;

   int idle_odds    = 4;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int frames_sent  = 0;
   int error_count;
   int awaited_count;

   aopd_req_if req_if ();
   aopd_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_ready;

   audio_onset_pulse_detector_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   onset_pulse_checker pulse_checker (
      .clock            (clock),
      .reset            (reset),
      .frame_bus        (req_if),
      .pulse_bus        (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .awaited_count    (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result receiver stalls at random in bursts of random length; idle_odds of zero stops it.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] random_sample(input int shift);
      logic signed [SAMPLE_W-1:0] raw;
      raw = SAMPLE_W'($urandom);
      return raw >>> shift;
   endfunction

   // Leaves valid high after the transaction; drain_block lowers it, the next call may.
   task automatic send_frame(input mode_type mode, input logic [SAMPLE_W-1:0] left,
                             input logic [SAMPLE_W-1:0] right);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.mode         <= mode;
      req_if.left_sample  <= left;
      req_if.right_sample <= right;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (mode != MODE_UNUSED)
         frames_sent++;
   endtask

   // A sample transaction gives no result, so the block may still be busy with one
   // after the last result is in; the settle time covers that.
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_poke(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic stereo, input logic [CSR_DATA_W-1:0] gain,
                                 input logic [CSR_DATA_W-1:0] peak,
                                 input logic [CSR_DATA_W-1:0] floor_v,
                                 input logic [CSR_DATA_W-1:0] decay);
      csr_poke(CSR_STEREO_INPUT, CSR_DATA_W'(stereo));
      csr_poke(CSR_THRESHOLD_GAIN, gain);
      csr_poke(CSR_PULSE_PEAK, peak);
      csr_poke(CSR_PULSE_FLOOR, floor_v);
      csr_poke(CSR_DECAY_FACTOR, decay);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_random_settings();
      logic [CSR_DATA_W-1:0] peak;
      logic [CSR_DATA_W-1:0] gain;
      logic [CSR_DATA_W-1:0] floor_v;
      peak = CSR_DATA_W'($urandom);
      // Small gains keep onsets frequent; large ones make them rare.
      if ($urandom_range(0, 1) == 1)
         gain = CSR_DATA_W'($urandom_range(0, 1024));
      else
         gain = CSR_DATA_W'($urandom);
      if ($urandom_range(0, 3) == 0)
         floor_v = CSR_DATA_W'($urandom);
      else
         floor_v = CSR_DATA_W'($urandom_range(0, peak / 4));
      apply_settings(1'($urandom), gain, peak, floor_v, CSR_DATA_W'($urandom));
   endtask

   // Mostly whole buffers with a loudness of their own, so that the power steps up
   // and down; the rest is silent ticks, ignored modes and ragged buffers.
   task automatic run_random(input int quota);
      int       target;
      int       len;
      int       shift;
      int       pick;
      mode_type mode;
      target = frames_sent + quota;
      while (frames_sent < target) begin
         pick  = $urandom_range(0, 99);
         shift = $urandom_range(0, 15);
         if ($urandom_range(0, 15) == 0)
            len = $urandom_range(13, 80);
         else
            len = $urandom_range(1, 12);
         if (pick < 75) begin
            for (int i = 1; i <= len; i++) begin
               mode = (i == len) ? MODE_END : MODE_SAMPLE;
               send_frame(mode, random_sample(shift), random_sample(shift));
            end
         end else if (pick < 87) begin
            send_frame(MODE_SILENT, random_sample(0), random_sample(0));
         end else if (pick < 93) begin
            send_frame(MODE_UNUSED, random_sample(0), random_sample(0));
         end else if (pick < 97) begin
            send_frame(MODE_END, random_sample(shift), random_sample(shift));
         end else begin
            // Samples with no end; they run into whatever buffer comes next.
            repeat (len) send_frame(MODE_SAMPLE, random_sample(shift), random_sample(shift));
         end
      end
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.mode         = MODE_SAMPLE;
      req_if.left_sample  = '0;
      req_if.right_sample = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(STEREO_RESET, GAIN_RESET, PEAK_RESET, FLOOR_RESET, DECAY_RESET);
      send_frame(MODE_SILENT, 16'h0000, 16'h0000);
      send_frame(MODE_SAMPLE, 16'h7FFF, 16'h7FFF);
      send_frame(MODE_END, 16'h8000, 16'h8000);
      // The stereo sum of -1 truncates to 0, and -3 halves to -1.
      send_frame(MODE_SAMPLE, 16'h7FFF, 16'h8000);
      send_frame(MODE_SAMPLE, 16'hFFFD, 16'h0000);
      send_frame(MODE_END, 16'h0001, 16'h0000);
      send_frame(MODE_UNUSED, 16'h8000, 16'h7FFF);
      send_frame(MODE_SILENT, 16'hFFFF, 16'hFFFF);
      send_frame(MODE_END, 16'h0000, 16'h0000);
      // Full-scale samples give a mean power of exactly one.
      send_frame(MODE_SAMPLE, 16'h8000, 16'h8000);
      send_frame(MODE_END, 16'h8000, 16'h8000);
      send_frame(MODE_SILENT, 16'h5555, 16'hAAAA);
      send_frame(MODE_SILENT, 16'hAAAA, 16'h5555);
      drain_block();

      // Mono, zero gain, widest peak and slowest decay.
      apply_settings(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_frame(MODE_SAMPLE, 16'h8000, 16'h7FFF);
      send_frame(MODE_END, 16'h7FFF, 16'h8000);
      send_frame(MODE_END, 16'h0001, 16'hFFFF);
      send_frame(MODE_SILENT, 16'h0000, 16'h0000);
      send_frame(MODE_UNUSED, 16'hFFFF, 16'h0000);
      run_random(250);
      drain_block();

      // Highest gain, zero peak, instant decay.
      idle_odds = 2;
      apply_settings(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      run_random(200);
      drain_block();

      // Floor above the peak: every amplitude should sit on the floor.
      idle_odds = 8;
      apply_settings(1'b1, 16'd256, 16'd1000, 16'd30000, 16'd32768);
      run_random(150);
      drain_block();

      repeat (3) begin
         idle_odds = 1 << $urandom_range(1, 4);
         apply_random_settings();
         run_random(270);
         drain_block();
      end

      idle_odds = 0;
      apply_settings(STEREO_RESET, GAIN_RESET, PEAK_RESET, FLOOR_RESET, DECAY_RESET);
      run_random(300);
      drain_block();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
